// ===== src/mmes_pkg.sv =====
// ----------------------------------------------------------------------------
// mmes_pkg: shared types and constants of the multitrack MIDI event sequencer
// Holds the command codes, item modes, event kinds and default geometry.
// ----------------------------------------------------------------------------
`default_nettype none
package mmes_pkg;

  localparam int unsigned TracksDef      = 8;
  localparam int unsigned LinesDef       = 1024;
  localparam int unsigned EventsPerTick  = 7;

  localparam logic [19:0] TempoReset = 20'd500000;
  localparam logic [15:0] TpqReset   = 16'd96;
  localparam logic [3:0]  TrkReset   = 4'd1;

  localparam int unsigned EvW = 49;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_START  = 3'd2,
    MODE_TIME   = 3'd3,
    MODE_STOP   = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    CMD_BANK   = 4'd0,
    CMD_NOTEON = 4'd1,
    CMD_NOTEOFF= 4'd2,
    CMD_PATCH  = 4'd3,
    CMD_VOLUME = 4'd4,
    CMD_PAN    = 4'd5,
    CMD_ALLOFF = 4'd6,
    CMD_STATUS = 4'd7,
    CMD_ACK    = 4'd8
  } cmd_e;

  localparam logic [2:0] KIND_NOTEON  = 3'd1;
  localparam logic [2:0] KIND_NOTEOFF = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd6;
  localparam logic [2:0] KIND_OTHER   = 3'd7;

  localparam logic [1:0] REG_TEMPO = 2'd0;
  localparam logic [1:0] REG_TPQ   = 2'd1;
  localparam logic [1:0] REG_TRK   = 2'd2;

  // one result transaction
  typedef struct packed {
    logic [2:0] channel;
    logic [3:0] command;
    logic [6:0] value_one;
    logic [6:0] value_two;
    logic       all_finished;
    logic       error;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

// ===== src/mmes_ram.sv =====
// ----------------------------------------------------------------------------
// mmes_ram: generic single-port synchronous RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module mmes_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write or read one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// ===== src/mmes_div.sv =====
// ----------------------------------------------------------------------------
// mmes_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mmes_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [35:0] num_i,
  input  wire logic [19:0] den_i,
  output logic             busy_o,
  output logic      [35:0] quot_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic [35:0] quo_q, quo_d;
  logic [20:0] rem_q, rem_d;
  logic [19:0] den_q, den_d;
  logic [20:0] trial;

  assign busy_o = (cnt_q != 6'd0);
  assign quot_o = quo_q;
  assign trial  = {rem_q[19:0], quo_q[35]};

  // shift in one numerator bit, subtract where it fits
  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = 6'd36;
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - 6'd1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[34:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[34:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule
`default_nettype wire

// ===== src/multitrack_midi_event_sequencer.sv =====
// ----------------------------------------------------------------------------
// multitrack_midi_event_sequencer: timed MIDI event player over track lists
// Event lists in one RAM, per-track counters in flip-flops, serial dividers.
// ----------------------------------------------------------------------------
// The block takes one input transaction at a time and accepts the next once
// the last result of the current one has been taken from the output
// register. A time transaction first works out the beat period with a serial
// division, then for every event read from the event RAM does one RAM read
// and two serial divisions, for at most 56 events in a busy millisecond. An
// idle track whose next event is not yet due costs the same read and both
// divisions; a finished track is passed over. The event RAM needs no
// clearing; entries are only read below each track's line count.
`default_nettype none
module multitrack_midi_event_sequencer #(
  parameter int unsigned TRACKS                = mmes_pkg::TracksDef,
  parameter int unsigned LINES_PER_TRACK       = mmes_pkg::LinesDef,
  parameter int unsigned EVENTS_PER_TRACK_TICK = mmes_pkg::EventsPerTick
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [2:0]  track_i,
  input  wire logic [15:0] beat_i,
  input  wire logic [15:0] tick_i,
  input  wire logic [2:0]  kind_i,
  input  wire logic [6:0]  first_value_i,
  input  wire logic [6:0]  second_value_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [19:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       channel_o,
  output logic [3:0]       command_o,
  output logic [6:0]       value_one_o,
  output logic [6:0]       value_two_o,
  output logic             all_finished_o,
  output logic             error_o,
  output logic             last_o
);
  import mmes_pkg::*;

  localparam int unsigned TW  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int unsigned LW  = $clog2(LINES_PER_TRACK);
  localparam int unsigned CW  = LW + 1;
  localparam int unsigned AW  = $clog2(TRACKS * LINES_PER_TRACK);
  localparam int unsigned EW  = $clog2(EVENTS_PER_TRACK_TICK + 1);
  localparam logic [4:0]  TRK_MAX = 5'(TRACKS);
  localparam logic [CW-1:0] LINES = CW'(LINES_PER_TRACK);
  // 2^30 / 1000 rounded up: exact quotient by 1000 for any 20-bit operand
  localparam logic [20:0] RECIP_1000 = 21'd1073742;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACK   = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_STOP  = 4'd3;
  localparam logic [3:0] S_BPS   = 4'd4;
  localparam logic [3:0] S_TRK   = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_D1    = 4'd7;
  localparam logic [3:0] S_D2    = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_STAT  = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [19:0] tempo_q;
  logic [15:0] tpq_q;
  logic [3:0]  tcnt_q;
  logic [CW-1:0] lcnt_q [TRACKS];
  logic [CW-1:0] rptr_q [TRACKS];

  logic [2:0]  mode_q;
  logic [2:0]  trk_q;
  logic        err_q;
  logic [31:0] now_q;
  logic [4:0]  ch_q;
  logic [1:0]  sub_q;
  logic [EW-1:0] done_q;
  logic [4:0]  fin_q;
  logic        phase_q;
  logic [19:0] bps_q;
  logic [35:0] due_q;
  logic [10:0] tq_q;
  logic [40:0] tq_prod;

  res_t        res_q;
  logic        ov_q;
  logic        emit;
  res_t        emit_r;
  logic        can_load;

  logic [4:0]  used;
  logic [19:0] tempo_eff;
  logic [15:0] tpq_eff;
  logic [TW-1:0] ch_idx;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EvW-1:0] ram_wdata, ram_rdata;

  // divider port
  logic        div_start, div_busy;
  logic [35:0] div_num, div_quot;
  logic [19:0] div_den;

  assign used      = (tcnt_q > TRK_MAX[3:0] || TRK_MAX > 5'd15) ?
                     ((TRK_MAX > 5'd15 && tcnt_q <= 4'd15) ? {1'b0, tcnt_q} : TRK_MAX)
                     : {1'b0, tcnt_q};
  assign tempo_eff = (tempo_q == 20'd0) ? 20'd1 : tempo_q;
  assign tpq_eff   = (tpq_q == 16'd0) ? 16'd1 : tpq_q;
  assign ch_idx    = TW'(ch_q);
  assign can_load  = !ov_q || !out_stall_i;

  // tempo in whole milliseconds per quarter by reciprocal multiplication
  assign tq_prod   = {21'd0, tempo_eff} * {20'd0, RECIP_1000};

  assign cfg_ready_o = (state_q == S_IDLE) && !in_valid_i;
  assign in_stall_o  = (state_q != S_IDLE);

  mmes_ram #(.Width(EvW), .Depth(TRACKS * LINES_PER_TRACK)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  mmes_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // event fields from RAM: beat, tick, kind, v1, v2
  logic [15:0] ev_beat, ev_tick;
  logic [2:0]  ev_kind;
  logic [6:0]  ev_v1, ev_v2;
  assign {ev_beat, ev_tick, ev_kind, ev_v1, ev_v2} = ram_rdata;

  logic [26:0] tick_prod;
  assign tick_prod = {11'd0, ev_tick} * {16'd0, tq_q};

  logic        trk_more;
  assign trk_more = (rptr_q[ch_idx] < lcnt_q[ch_idx]) && (rptr_q[ch_idx] < LINES);

  // RAM address and write data
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {beat_i, tick_i, kind_i, first_value_i, second_value_i};
    ram_addr  = AW'({ch_idx, rptr_q[ch_idx][LW-1:0]});
    if (TRACKS == 1) begin
      ram_addr = AW'(rptr_q[ch_idx][LW-1:0]);
    end
    if (state_q == S_IDLE && in_valid_i && mode_i == MODE_APPEND &&
        {2'b0, track_i} < TRK_MAX &&
        lcnt_q[TW'(track_i)] < LINES) begin
      ram_we   = 1'b1;
      ram_addr = (TRACKS == 1) ? AW'(lcnt_q[0][LW-1:0]) :
                 AW'({TW'(track_i), lcnt_q[TW'(track_i)][LW-1:0]});
    end
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = 36'd1000000;
    div_den   = tempo_eff;
    case (state_q)
      S_IDLE: begin
        div_start = in_valid_i && mode_i == MODE_TIME;
      end
      S_D1: begin
        div_start = !phase_q;
        div_num   = {10'd0, ev_beat, 10'd0} - {16'd0, ev_beat, 4'd0}
                    - {17'd0, ev_beat, 3'd0};
        div_den   = bps_q;
      end
      S_D2: begin
        div_start = !phase_q;
        div_num   = {9'd0, tick_prod};
        div_den   = {4'd0, tpq_eff};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // result of the current event
  always_comb begin
    emit   = 1'b0;
    emit_r = '0;
    emit_r.channel = 3'(ch_q);
    case (state_q)
      S_ACK: begin
        emit = 1'b1;
        emit_r.command = CMD_ACK;
        emit_r.channel = (mode_q == MODE_APPEND) ? trk_q : 3'd0;
        emit_r.error   = err_q;
        emit_r.last    = 1'b1;
      end
      S_START: begin
        emit = 1'b1;
        if (ch_q >= used) begin
          emit_r.command = CMD_ACK;
          emit_r.channel = 3'd0;
          emit_r.last    = 1'b1;
        end else begin
          emit_r.command = (sub_q == 2'd0) ? CMD_BANK :
                           (sub_q == 2'd1) ? CMD_PATCH : CMD_VOLUME;
          emit_r.value_one = (sub_q == 2'd2) ? 7'd127 : 7'd0;
        end
      end
      S_STOP: begin
        emit = 1'b1;
        if (ch_q >= used) begin
          emit_r.command = CMD_ACK;
          emit_r.channel = 3'd0;
          emit_r.last    = 1'b1;
        end else begin
          emit_r.command = CMD_ALLOFF;
        end
      end
      S_EMIT: begin
        emit = (ev_kind != KIND_OTHER);
        emit_r.value_one = ev_v1;
        case (ev_kind)
          KIND_NOTEON: begin
            emit_r.command   = (ev_v2 == 7'd0) ? CMD_NOTEOFF : CMD_NOTEON;
            emit_r.value_two = ev_v2;
          end
          KIND_NOTEOFF: begin
            emit_r.command   = CMD_NOTEOFF;
            emit_r.value_two = ev_v2;
          end
          KIND_END: begin
            emit_r.command   = CMD_ALLOFF;
            emit_r.value_one = 7'd0;
          end
          default: begin
            emit_r.command = {1'b0, ev_kind};
          end
        endcase
      end
      S_STAT: begin
        emit = 1'b1;
        emit_r.channel      = 3'd0;
        emit_r.command      = CMD_STATUS;
        emit_r.all_finished = (fin_q == used);
        emit_r.last         = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  logic [35:0] due_sum;
  assign due_sum = due_q + div_quot;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            MODE_START: state_d = S_START;
            MODE_STOP:  state_d = S_STOP;
            MODE_TIME:  state_d = S_BPS;
            default:    state_d = S_ACK;
          endcase
        end
      end
      S_ACK:   if (can_load) state_d = S_WAIT;
      S_START: if (can_load && ch_q >= used) state_d = S_WAIT;
      S_STOP:  if (can_load && ch_q >= used) state_d = S_WAIT;
      S_BPS:   if (!div_busy) state_d = S_TRK;
      S_TRK: begin
        if (ch_q >= used) begin
          state_d = S_STAT;
        end else if (trk_more && done_q < EW'(EVENTS_PER_TRACK_TICK)) begin
          state_d = S_RD;
        end
      end
      S_RD:  state_d = S_D1;
      S_D1:  if (phase_q && !div_busy) state_d = S_D2;
      S_D2: begin
        if (phase_q && !div_busy) begin
          state_d = (due_sum > {4'd0, now_q}) ? S_TRK : S_EMIT;
        end
      end
      S_EMIT:  if (!emit || can_load) state_d = S_TRK;
      S_STAT:  if (can_load) state_d = S_WAIT;
      S_WAIT:  if (can_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tempo_q <= TempoReset;
      tpq_q   <= TpqReset;
      tcnt_q  <= TrkReset;
      ov_q    <= 1'b0;
      ch_q    <= '0;
      sub_q   <= '0;
      done_q  <= '0;
      fin_q   <= '0;
      phase_q <= 1'b0;
      for (int i = 0; i < TRACKS; i++) begin
        lcnt_q[i] <= '0;
        rptr_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TEMPO: tempo_q <= cfg_data_i;
          REG_TPQ:   tpq_q   <= cfg_data_i[15:0];
          REG_TRK:   tcnt_q  <= cfg_data_i[3:0];
          default:   tcnt_q  <= tcnt_q;
        endcase
      end
      // output register
      if (emit && can_load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          ch_q    <= '0;
          sub_q   <= '0;
          done_q  <= '0;
          fin_q   <= '0;
          phase_q <= 1'b0;
          if (in_valid_i && mode_i == MODE_CLEAR) begin
            for (int i = 0; i < TRACKS; i++) begin
              lcnt_q[i] <= '0;
              rptr_q[i] <= '0;
            end
          end
          if (ram_we) begin
            lcnt_q[TW'(track_i)] <= lcnt_q[TW'(track_i)] + CW'(1);
          end
        end
        S_START: begin
          if (can_load && ch_q < used) begin
            rptr_q[ch_idx] <= '0;
            if (sub_q == 2'd2) begin
              sub_q <= '0;
              ch_q  <= ch_q + 5'd1;
            end else begin
              sub_q <= sub_q + 2'd1;
            end
          end
        end
        S_STOP: begin
          if (can_load && ch_q < used) ch_q <= ch_q + 5'd1;
        end
        S_TRK: begin
          if (ch_q < used && !(trk_more && done_q < EW'(EVENTS_PER_TRACK_TICK))) begin
            if (!trk_more) fin_q <= fin_q + 5'd1;
            ch_q   <= ch_q + 5'd1;
            done_q <= '0;
          end
        end
        S_D1: begin
          if (!phase_q) begin
            phase_q <= 1'b1;
          end else if (!div_busy) begin
            phase_q <= 1'b0;
          end
        end
        S_D2: begin
          if (!phase_q) begin
            phase_q <= 1'b1;
          end else if (!div_busy) begin
            phase_q <= 1'b0;
            // leave this track once its next event is not yet due
            if (due_sum > {4'd0, now_q}) done_q <= EW'(EVENTS_PER_TRACK_TICK);
          end
        end
        S_EMIT: begin
          if (!emit || can_load) begin
            rptr_q[ch_idx] <= rptr_q[ch_idx] + CW'(1);
            done_q <= done_q + EW'(1);
          end
        end
        default: begin
          phase_q <= 1'b0;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (emit && can_load) res_q <= emit_r;
    if (state_q == S_IDLE && in_valid_i) begin
      mode_q <= mode_i;
      trk_q  <= track_i;
      now_q  <= now_ms_i;
      err_q  <= !ram_we && mode_i == MODE_APPEND;
    end
    if (state_q == S_BPS) tq_q <= tq_prod[40:30];
    if (state_q == S_BPS && !div_busy) begin
      bps_q <= (div_quot == 36'd0) ? 20'd1 : div_quot[19:0];
    end
    if (state_q == S_D1 && phase_q && !div_busy) due_q <= div_quot;
  end

  assign out_valid_o    = ov_q;
  assign channel_o      = res_q.channel;
  assign command_o      = res_q.command;
  assign value_one_o    = res_q.value_one;
  assign value_two_o    = res_q.value_two;
  assign all_finished_o = res_q.all_finished;
  assign error_o        = res_q.error;
  assign last_o         = res_q.last;
endmodule
`default_nettype wire

// ===== src/mmes_checker.sv =====
// ----------------------------------------------------------------------------
// mmes_checker: port-level checks of the sequencer
// Watches the handshakes and result framing from the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none
module mmes_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] command_o,
  input wire logic       last_o,
  input wire logic       error_o
);
  import mmes_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(command_o) && $stable(last_o))
    else $error("stalled result changed");

  // take no transaction while busy with another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction taken back to back");

  // status always closes its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == CMD_STATUS |-> last_o)
    else $error("status not last");

  // flag errors only on acks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> command_o == CMD_ACK)
    else $error("error outside ack");

  // accept configuration only between transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> !in_stall_o)
    else $error("config taken while busy");
endmodule

bind multitrack_midi_event_sequencer mmes_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .command_o   (command_o),
  .last_o      (last_o),
  .error_o     (error_o)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the multitrack MIDI event sequencer
// Walks a directed table, then runs random sessions (configure, clear,
// append, start, time, stop) with bursty input and a stalling receiver;
// every result is checked against a local predictor or a given expected ack.
// ----------------------------------------------------------------------------
module testbench;
  import mmes_pkg::*;

  localparam int unsigned NTRK      = 8;
  localparam int unsigned NLINE     = 1024;
  localparam int unsigned PER_TICK  = 7;
  localparam int unsigned CYC_LIMIT = 3000000;
  localparam int unsigned HOLD_CYC  = 3000;

  localparam logic [2:0] MODE_SPARE_A = 3'd5;
  localparam logic [2:0] MODE_SPARE_B = 3'd6;
  localparam logic [2:0] MODE_SPARE_C = 3'd7;
  localparam logic [2:0] KIND_BANK    = 3'(CMD_BANK);
  localparam logic [2:0] KIND_PATCH   = 3'(CMD_PATCH);
  localparam logic [2:0] KIND_VOLUME  = 3'(CMD_VOLUME);
  localparam logic [2:0] KIND_PAN     = 3'(CMD_PAN);

  typedef struct {
    logic [2:0]  mode;
    logic [2:0]  track;
    logic [15:0] beat;
    logic [15:0] tick;
    logic [2:0]  kind;
    logic [6:0]  v1;
    logic [6:0]  v2;
    logic [31:0] now;
    bit          lit;
    res_t        res;
  } seq_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [2:0]  track_i = '0;
  logic [15:0] beat_i = '0;
  logic [15:0] tick_i = '0;
  logic [2:0]  kind_i = '0;
  logic [6:0]  first_value_i = '0;
  logic [6:0]  second_value_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  channel_o;
  logic [3:0]  command_o;
  logic [6:0]  value_one_o;
  logic [6:0]  value_two_o;
  logic        all_finished_o;
  logic        error_o;
  logic        last_o;

  multitrack_midi_event_sequencer dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [15:0] ev_beat [NTRK][NLINE];
  logic [15:0] ev_tick [NTRK][NLINE];
  logic [2:0]  ev_kind [NTRK][NLINE];
  logic [6:0]  ev_v1   [NTRK][NLINE];
  logic [6:0]  ev_v2   [NTRK][NLINE];
  int unsigned lines [NTRK];
  int unsigned play_ptr [NTRK];
  logic [19:0] tempo_reg = TempoReset;
  logic [15:0] tpq_reg = TpqReset;
  logic [3:0]  trk_reg = TrkReset;

  res_t        pending_res [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit          hold_req = 1'b0;

  function automatic res_t mk_res(logic [2:0] ch, cmd_e cmd, logic [6:0] a, logic [6:0] b,
                                  logic fin, logic err);
    res_t r;
    r = '{channel: ch, command: cmd, value_one: a, value_two: b,
          all_finished: fin, error: err, last: 1'b0};
    return r;
  endfunction

  // work out the results of one accepted transaction and advance the model
  task automatic play_item(input seq_item_t it, output res_t rq [$]);
    int unsigned n, tempo, bps, ppqn, fin, rp;
    logic [63:0] due;
    rq = {};
    n = (trk_reg > NTRK) ? NTRK : trk_reg;
    case (it.mode)
      MODE_CLEAR: begin
        foreach (lines[t]) begin
          lines[t] = 0;
          play_ptr[t] = 0;
        end
        rq.push_back(mk_res(0, CMD_ACK, 0, 0, 0, 0));
      end
      MODE_APPEND: begin
        if (lines[it.track] < NLINE) begin
          rp = lines[it.track];
          ev_beat[it.track][rp] = it.beat;
          ev_tick[it.track][rp] = it.tick;
          ev_kind[it.track][rp] = it.kind;
          ev_v1[it.track][rp]   = it.v1;
          ev_v2[it.track][rp]   = it.v2;
          lines[it.track]++;
          rq.push_back(mk_res(it.track, CMD_ACK, 0, 0, 0, 0));
        end else begin
          rq.push_back(mk_res(it.track, CMD_ACK, 0, 0, 0, 1));
        end
      end
      MODE_START: begin
        for (int c = 0; c < n; c++) begin
          play_ptr[c] = 0;
          rq.push_back(mk_res(c, CMD_BANK, 0, 0, 0, 0));
          rq.push_back(mk_res(c, CMD_PATCH, 0, 0, 0, 0));
          rq.push_back(mk_res(c, CMD_VOLUME, 127, 0, 0, 0));
        end
        rq.push_back(mk_res(0, CMD_ACK, 0, 0, 0, 0));
      end
      MODE_TIME: begin
        tempo = (tempo_reg == 0) ? 1 : tempo_reg;
        bps   = 1000000 / tempo;
        if (bps == 0) bps = 1;
        ppqn  = (tpq_reg == 0) ? 1 : tpq_reg;
        fin   = 0;
        for (int c = 0; c < n; c++) begin
          for (int d = 0; d < PER_TICK; d++) begin
            rp = play_ptr[c];
            if (rp >= lines[c]) break;
            due = (64'(ev_beat[c][rp]) * 1000) / bps
                + (64'(ev_tick[c][rp]) * (tempo / 1000)) / ppqn;
            if (due > 64'(it.now)) break;
            case (ev_kind[c][rp])
              KIND_NOTEON:
                if (ev_v2[c][rp] == 0) rq.push_back(mk_res(c, CMD_NOTEOFF, ev_v1[c][rp], 0, 0, 0));
                else rq.push_back(mk_res(c, CMD_NOTEON, ev_v1[c][rp], ev_v2[c][rp], 0, 0));
              KIND_NOTEOFF: rq.push_back(mk_res(c, CMD_NOTEOFF, ev_v1[c][rp], ev_v2[c][rp], 0, 0));
              KIND_END:     rq.push_back(mk_res(c, CMD_ALLOFF, 0, 0, 0, 0));
              KIND_OTHER:   ;
              default:      rq.push_back(mk_res(c, cmd_e'({1'b0, ev_kind[c][rp]}),
                                                ev_v1[c][rp], 0, 0, 0));
            endcase
            play_ptr[c] = rp + 1;
          end
          if (play_ptr[c] >= lines[c]) fin++;
        end
        rq.push_back(mk_res(0, CMD_STATUS, 0, 0, fin == n, 0));
      end
      MODE_STOP: begin
        for (int c = 0; c < n; c++) rq.push_back(mk_res(c, CMD_ALLOFF, 0, 0, 0, 0));
        rq.push_back(mk_res(0, CMD_ACK, 0, 0, 0, 0));
      end
      default: rq.push_back(mk_res(0, CMD_ACK, 0, 0, 0, 0));
    endcase
    rq[$].last = 1'b1;
  endtask

  // drive one transaction, hold it until taken, then queue its results
  task automatic send(input seq_item_t it);
    res_t rq [$];
    in_valid_i     <= 1'b1;
    mode_i         <= it.mode;
    track_i        <= it.track;
    beat_i         <= it.beat;
    tick_i         <= it.tick;
    kind_i         <= it.kind;
    first_value_i  <= it.v1;
    second_value_i <= it.v2;
    now_ms_i       <= it.now;
    do @(posedge clk_i); while (in_stall_o);
    play_item(it, rq);
    if (it.lit) pending_res.push_back(it.res);
    else foreach (rq[i]) pending_res.push_back(rq[i]);
    items_sent++;
  endtask

  // bursty sender: occasionally drop valid for a random gap
  int unsigned burst_left = 0;
  task automatic send_bursty(input seq_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    burst_left--;
    send(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [19:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_TEMPO: tempo_reg = data;
      REG_TPQ:   tpq_reg = data[15:0];
      REG_TRK:   trk_reg = data[3:0];
      default:   ;
    endcase
  endtask

  function automatic seq_item_t row(logic [2:0] m, logic [2:0] t, logic [15:0] b,
                                    logic [15:0] tk, logic [2:0] k, logic [6:0] a,
                                    logic [6:0] v, logic [31:0] nw);
    seq_item_t it;
    it = '{mode: m, track: t, beat: b, tick: tk, kind: k, v1: a, v2: v, now: nw,
           lit: 1'b0, res: '0};
    return it;
  endfunction

  function automatic seq_item_t ack_row(seq_item_t it, logic [2:0] ch);
    it.lit = 1'b1;
    it.res = mk_res(ch, CMD_ACK, 0, 0, 0, 0);
    it.res.last = 1'b1;
    return it;
  endfunction

  function automatic seq_item_t rand_event(int unsigned ntr);
    return row(MODE_APPEND, (ntr == 0 || $urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(0, ntr - 1)),
               16'($urandom_range(0, 30)), 16'($urandom_range(0, 500)),
               3'($urandom), 7'($urandom),
               ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom), 32'($urandom));
  endfunction

  // ticker and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall pattern, quiet stretches, and one long hold-off
  initial begin
    int unsigned pct, span;
    forever begin
      pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
      span = $urandom_range(20, 300);
      for (int i = 0; i < span && !hold_req; i++) begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
        @(posedge clk_i);
      end
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result: channel %0d command %0d", channel_o, command_o);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (channel_o !== e.channel) begin
          $error("channel: expected %0d got %0d", e.channel, channel_o); errors++;
        end
        if (command_o !== e.command) begin
          $error("command: expected %0d got %0d", e.command, command_o); errors++;
        end
        if (value_one_o !== e.value_one) begin
          $error("value_one: expected %0d got %0d", e.value_one, value_one_o); errors++;
        end
        if (value_two_o !== e.value_two) begin
          $error("value_two: expected %0d got %0d", e.value_two, value_two_o); errors++;
        end
        if (all_finished_o !== e.all_finished) begin
          $error("all_finished: expected %0d got %0d", e.all_finished, all_finished_o);
          errors++;
        end
        if (error_o !== e.error) begin
          $error("error: expected %0d got %0d", e.error, error_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d got %0d", e.last, last_o); errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    seq_item_t dir_tab [$];
    seq_item_t it;
    logic [31:0] now;
    int unsigned ntr, sess;

    foreach (lines[t]) begin
      lines[t] = 0;
      play_ptr[t] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table: extremes, every kind and mode, special cases
    dir_tab.push_back(ack_row(row(MODE_CLEAR, 3'd7, 16'hFFFF, 16'hFFFF, 3'd7, 7'h7F, 7'h7F,
                                  32'hFFFFFFFF), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 0, 0, 0, KIND_BANK, 127, 127, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 0, 0, 0, KIND_NOTEON, 60, 0, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 0, 0, 16'hFFFF, KIND_NOTEON, 127, 127, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 0, 1, 0, KIND_NOTEOFF, 5, 9, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 0, 1, 3, KIND_PATCH, 3, 77, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 0, 1, 4, KIND_VOLUME, 100, 1, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 0, 1, 5, KIND_PAN, 64, 2, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 0, 1, 6, KIND_OTHER, 1, 1, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 0, 16'hFFFF, 16'hFFFF, KIND_END, 0, 0, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_APPEND, 7, 2, 0, KIND_NOTEON, 10, 20, 0), 7));
    dir_tab.push_back(ack_row(row(MODE_SPARE_A, 5, 0, 0, 0, 0, 0, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_SPARE_B, 6, 0, 0, 0, 0, 0, 0), 0));
    dir_tab.push_back(ack_row(row(MODE_SPARE_C, 1, 0, 0, 0, 0, 0, 0), 0));
    dir_tab.push_back(row(MODE_START, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(MODE_TIME, 0, 0, 0, 0, 0, 0, 32'd0));
    dir_tab.push_back(row(MODE_TIME, 0, 0, 0, 0, 0, 0, 32'd700));
    dir_tab.push_back(row(MODE_TIME, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
    dir_tab.push_back(row(MODE_TIME, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
    dir_tab.push_back(row(MODE_STOP, 0, 0, 0, 0, 0, 0, 0));
    foreach (dir_tab[i]) send(dir_tab[i]);

    // random sessions
    sess = 0;
    while (items_sent < 390) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: cfg_write(REG_TEMPO, 20'd1000);
        1: cfg_write(REG_TEMPO, 20'd1000000);
        2: cfg_write(REG_TEMPO, 20'd0);
        3: cfg_write(REG_TEMPO, 20'hFFFFF);
        4: cfg_write(REG_TEMPO, 20'd500000);
        default: cfg_write(REG_TEMPO, 20'($urandom_range(1000, 1000000)));
      endcase
      case ($urandom_range(0, 4))
        0: cfg_write(REG_TPQ, 20'd0);
        1: cfg_write(REG_TPQ, 20'd1);
        2: cfg_write(REG_TPQ, 20'd65535);
        default: cfg_write(REG_TPQ, 20'($urandom_range(1, 480)));
      endcase
      case ($urandom_range(0, 5))
        0: cfg_write(REG_TRK, 20'd0);
        1: cfg_write(REG_TRK, 20'd15);
        2: cfg_write(REG_TRK, 20'd8);
        default: cfg_write(REG_TRK, 20'($urandom_range(1, 8)));
      endcase
      ntr = (trk_reg > NTRK) ? NTRK : trk_reg;
      if ($urandom_range(0, 9) != 0) send_bursty(row(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      repeat ($urandom_range(0, 30)) send_bursty(rand_event(ntr));
      send_bursty(row(MODE_START, 3'($urandom), 0, 0, 0, 0, 0, 0));
      if (sess == 2) hold_req = 1'b1;
      now = 0;
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 9) == 0) begin
          it = row(3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom), 3'($urandom),
                   7'($urandom), 7'($urandom), 32'($urandom));
          if (it.mode == MODE_CLEAR || it.mode == MODE_APPEND) it.mode = MODE_SPARE_A;
          send_bursty(it);
        end
        now = ($urandom_range(0, 20) == 0) ? 32'hFFFFFFFF : now + $urandom_range(0, 5000);
        send_bursty(row(MODE_TIME, 0, 0, 0, 0, 0, 0, now));
      end
      if ($urandom_range(0, 1) != 0) send_bursty(row(MODE_STOP, 0, 0, 0, 0, 0, 0, 0));
      sess++;
    end

    // drain and report
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mmes_pkg.sv
src/mmes_ram.sv
src/mmes_div.sv
src/multitrack_midi_event_sequencer.sv
src/mmes_checker.sv
tb/testbench.sv
